// ----- sv/blca_pkg.sv -----
// Shared types for the binary lifting ancestor and LCA unit.
package blca_pkg;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_BUILD = 2'd1,
		KIND_KTH   = 2'd2,
		KIND_LCA   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {NSEL_J, NSEL_A, NSEL_B, NSEL_RD} node_sel_t;
	typedef enum logic [1:0] {LSEL_ZERO, LSEL_LVL, LSEL_PREV} lvl_sel_t;
	typedef enum logic [1:0] {WSEL_J, WSEL_B, WSEL_RD} wdata_sel_t;
	typedef enum logic [1:0] {RES_NONE, RES_A, RES_PAR} res_sel_t;

	typedef struct packed {
		logic       tbl_re;
		node_sel_t  rd_node;
		lvl_sel_t   rd_lvl;
		logic       tbl_we;
		node_sel_t  wr_node;
		lvl_sel_t   wr_lvl;
		wdata_sel_t wr_data;
		logic       dep_re;
		logic       dep_rd_b;
		logic       dep_we;
		logic       load_in;
		logic       j_init;
		logic       j_inc;
		logic       lvl_one;
		logic       lvl_top;
		logic       lvl_inc;
		logic       lvl_dec;
		logic       a_ld_rd;
		logic       a_ld_j;
		logic       d_inc;
		logic       d_ld_dep;
		logic       depth_cmp;
		logic       t_ld_rd;
		logic       lift;
		logic       res_set;
		res_sel_t   res_sel;
		logic       out_load;
		logic       ready_set;
		logic       ready_clr;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  a_valid;
		logic  b_valid;
		logic  rd_valid;
		logic  ready;
		logic  j_in_range;
		logic  lvl_lt;
		logic  lvl_zero;
		logic  k_bit;
		logic  walk_on;
		logic  a_eq_b;
		logic  out_free;
	} status_t;

endpackage

// ----- sv/binary_lifting_ancestor_lca_unit.sv -----
// Top level of the binary lifting ancestor and lowest common ancestor unit.
// Input transactions on s_axis carry one command: tuser is the kind (load parent,
// build table, k-th ancestor query, LCA query), tdata carries node_a, node_b, steps.
// Loads and builds produce no output; each query produces one m_axis transaction
// with the answer node in tdata and the found flag in tuser.
// cfg_we with cfg_wdata sets the node count; write it only while the unit is idle.
// A load writes node_b as the parent of a valid node_a. A build fills level 0,
// then each higher level from the level below, then walks the parents of each node
// to find its depth; every step is a read of the single ancestor table port.
// A k-th ancestor query reads one table entry per set bit of steps; an LCA query
// reads both depths and then does one table read per lifted level and node.
// One command is worked at a time; s_axis_tready is high only when the unit is idle.
// A finished answer waits in the output register while the unit takes the next
// command; a stalled receiver holds the unit only when the next answer is ready.
// Reset clears the node count to 1, marks the table as not built and empties the
// output; the memories keep their contents and hold no meaning until written.
module binary_lifting_ancestor_lca_unit
	import blca_pkg::*;
#(
	parameter int NODES  = 256,
	parameter int LEVELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // node_a, node_b, steps
	input  logic [1:0]  s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // answer_node
	output logic [0:0]  m_axis_tuser    // found
);

	cmd_t    cmd;
	status_t st;
	kind_t   in_kind;
	logic    out_found;

	assign in_kind = kind_t'(s_axis_tuser);

	blca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (in_kind),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	blca_dp #(.NODES(NODES), .LEVELS(LEVELS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_kind   (in_kind),
		.in_node_a (s_axis_tdata[7:0]),
		.in_node_b (s_axis_tdata[15:8]),
		.in_steps  (s_axis_tdata[23:16]),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_node  (m_axis_tdata),
		.out_found (out_found)
	);

	assign m_axis_tuser = out_found;

endmodule

// ----- sv/blca_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module blca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/blca_ctrl.sv -----
// Sequencing state machine for loads, builds and queries.
module blca_ctrl
	import blca_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  kind_t   in_kind,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_B0_CHK, S_B0_USE, S_B1_CHK, S_B1_T, S_B1_W,
		S_B2_CHK, S_B2_RD, S_B2_USE, S_Q_CHK, S_D_A, S_D_B, S_D_CMP,
		S_CL_CHK, S_CL_USE, S_CL_DONE, S_LF_A, S_LF_B, S_LF_USE,
		S_P_A, S_P_B, S_P_USE, S_OUT
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cmd.j_init  = 1'b1;
					unique case (in_kind)
						KIND_LOAD:  state_d = S_LOAD;
						KIND_BUILD: state_d = S_B0_CHK;
						default:    state_d = S_Q_CHK;
					endcase
				end
			end
			S_LOAD: begin
				if (st.a_valid) begin
					cmd.tbl_we    = 1'b1;
					cmd.wr_node   = NSEL_A;
					cmd.wr_lvl    = LSEL_ZERO;
					cmd.wr_data   = WSEL_B;
					cmd.ready_clr = 1'b1;
				end
				state_d = S_IDLE;
			end
			S_B0_CHK: begin
				if (st.j_in_range) begin
					cmd.tbl_re  = 1'b1;
					cmd.rd_node = NSEL_J;
					cmd.rd_lvl  = LSEL_ZERO;
					state_d     = S_B0_USE;
				end else begin
					cmd.lvl_one = 1'b1;
					cmd.j_init  = 1'b1;
					state_d     = S_B1_CHK;
				end
			end
			S_B0_USE: begin
				if (!st.rd_valid) begin
					cmd.tbl_we  = 1'b1;
					cmd.wr_node = NSEL_J;
					cmd.wr_lvl  = LSEL_ZERO;
					cmd.wr_data = WSEL_J;
				end
				cmd.j_inc = 1'b1;
				state_d   = S_B0_CHK;
			end
			S_B1_CHK: begin
				if (!st.lvl_lt) begin
					cmd.j_init = 1'b1;
					state_d    = S_B2_CHK;
				end else if (st.j_in_range) begin
					cmd.tbl_re  = 1'b1;
					cmd.rd_node = NSEL_J;
					cmd.rd_lvl  = LSEL_PREV;
					state_d     = S_B1_T;
				end else begin
					cmd.lvl_inc = 1'b1;
					cmd.j_init  = 1'b1;
				end
			end
			S_B1_T: begin
				cmd.tbl_re  = 1'b1;
				cmd.rd_node = NSEL_RD;
				cmd.rd_lvl  = LSEL_PREV;
				state_d     = S_B1_W;
			end
			S_B1_W: begin
				cmd.tbl_we  = 1'b1;
				cmd.wr_node = NSEL_J;
				cmd.wr_lvl  = LSEL_LVL;
				cmd.wr_data = WSEL_RD;
				cmd.j_inc   = 1'b1;
				state_d     = S_B1_CHK;
			end
			S_B2_CHK: begin
				if (st.j_in_range) begin
					cmd.a_ld_j = 1'b1;
					state_d    = S_B2_RD;
				end else begin
					cmd.ready_set = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_B2_RD: begin
				cmd.tbl_re  = 1'b1;
				cmd.rd_node = NSEL_A;
				cmd.rd_lvl  = LSEL_ZERO;
				state_d     = S_B2_USE;
			end
			S_B2_USE: begin
				if (st.walk_on) begin
					cmd.a_ld_rd = 1'b1;
					cmd.d_inc   = 1'b1;
					state_d     = S_B2_RD;
				end else begin
					cmd.dep_we = 1'b1;
					cmd.j_inc  = 1'b1;
					state_d    = S_B2_CHK;
				end
			end
			S_Q_CHK: begin
				if (!st.ready || !st.a_valid || (st.kind == KIND_LCA && !st.b_valid)) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_NONE;
					state_d     = S_OUT;
				end else if (st.kind == KIND_LCA) begin
					state_d = S_D_A;
				end else begin
					state_d = S_CL_CHK;
				end
			end
			S_D_A: begin
				cmd.dep_re = 1'b1;
				state_d    = S_D_B;
			end
			S_D_B: begin
				cmd.dep_re   = 1'b1;
				cmd.dep_rd_b = 1'b1;
				cmd.d_ld_dep = 1'b1;
				state_d      = S_D_CMP;
			end
			S_D_CMP: begin
				cmd.depth_cmp = 1'b1;
				state_d       = S_CL_CHK;
			end
			S_CL_CHK: begin
				if (st.k_bit) begin
					cmd.tbl_re  = 1'b1;
					cmd.rd_node = NSEL_A;
					cmd.rd_lvl  = LSEL_LVL;
					state_d     = S_CL_USE;
				end else if (st.lvl_zero) begin
					state_d = S_CL_DONE;
				end else begin
					cmd.lvl_dec = 1'b1;
				end
			end
			S_CL_USE: begin
				cmd.a_ld_rd = 1'b1;
				if (st.lvl_zero) begin
					state_d = S_CL_DONE;
				end else begin
					cmd.lvl_dec = 1'b1;
					state_d     = S_CL_CHK;
				end
			end
			S_CL_DONE: begin
				if (st.kind == KIND_KTH || st.a_eq_b) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_A;
					state_d     = S_OUT;
				end else begin
					cmd.lvl_top = 1'b1;
					state_d     = S_LF_A;
				end
			end
			S_LF_A: begin
				cmd.tbl_re  = 1'b1;
				cmd.rd_node = NSEL_A;
				cmd.rd_lvl  = LSEL_LVL;
				state_d     = S_LF_B;
			end
			S_LF_B: begin
				cmd.t_ld_rd = 1'b1;
				cmd.tbl_re  = 1'b1;
				cmd.rd_node = NSEL_B;
				cmd.rd_lvl  = LSEL_LVL;
				state_d     = S_LF_USE;
			end
			S_LF_USE: begin
				cmd.lift = 1'b1;
				if (st.lvl_zero) begin
					state_d = S_P_A;
				end else begin
					cmd.lvl_dec = 1'b1;
					state_d     = S_LF_A;
				end
			end
			S_P_A: begin
				cmd.tbl_re  = 1'b1;
				cmd.rd_node = NSEL_A;
				cmd.rd_lvl  = LSEL_ZERO;
				state_d     = S_P_B;
			end
			S_P_B: begin
				cmd.t_ld_rd = 1'b1;
				cmd.tbl_re  = 1'b1;
				cmd.rd_node = NSEL_B;
				cmd.rd_lvl  = LSEL_ZERO;
				state_d     = S_P_USE;
			end
			S_P_USE: begin
				cmd.res_set = 1'b1;
				cmd.res_sel = RES_PAR;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/blca_dp.sv -----
// Datapath: ancestor and depth memories, work registers and result register.
module blca_dp
	import blca_pkg::*;
#(
	parameter int NODES  = 256,
	parameter int LEVELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  kind_t       in_kind,
	input  logic [7:0]  in_node_a,
	input  logic [7:0]  in_node_b,
	input  logic [7:0]  in_steps,
	input  cmd_t        cmd,
	output status_t     st,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_node,
	output logic        out_found
);

	localparam int NW = $clog2(NODES);
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int TDEPTH = NODES * (2 ** LW);

	logic [7:0]        node_count_q;
	logic              ready_q;
	kind_t             kind_q;
	logic [7:0]        a_q, b_q, t_q;
	logic [LEVELS-1:0] k_q;
	logic [8:0]        j_q;
	logic [LW:0]       lvl_q;
	logic [8:0]        d_q;
	logic [7:0]        res_node_q;
	logic              res_found_q;
	logic              out_valid_q;
	logic [7:0]        out_node_q;
	logic              out_found_q;

	logic [7:0]        tbl_rd, rd_node, wr_node, wr_data;
	logic [LW-1:0]     rd_lvl, wr_lvl, lvl_idx, lvl_prev;
	logic [NW+LW-1:0]  tbl_raddr, tbl_waddr;
	logic [8:0]        dep_rd;
	logic [NW-1:0]     dep_raddr;

	function automatic logic node_ok(logic [7:0] x, logic [7:0] cnt);
		return (x != 8'd0) && (x <= cnt) && (32'(x) < NODES);
	endfunction

	assign lvl_idx  = lvl_q[LW-1:0];
	assign lvl_prev = lvl_idx - LW'(1);

	always_comb begin
		case (cmd.rd_node)
			NSEL_J:  rd_node = j_q[7:0];
			NSEL_A:  rd_node = a_q;
			NSEL_B:  rd_node = b_q;
			default: rd_node = tbl_rd;
		endcase
		case (cmd.rd_lvl)
			LSEL_LVL:  rd_lvl = lvl_idx;
			LSEL_PREV: rd_lvl = lvl_prev;
			default:   rd_lvl = '0;
		endcase
		wr_node = (cmd.wr_node == NSEL_A) ? a_q : j_q[7:0];
		wr_lvl  = (cmd.wr_lvl == LSEL_LVL) ? lvl_idx : '0;
		case (cmd.wr_data)
			WSEL_B:  wr_data = b_q;
			WSEL_RD: wr_data = tbl_rd;
			default: wr_data = j_q[7:0];
		endcase
	end

	assign tbl_raddr = {NW'(rd_node), rd_lvl};
	assign tbl_waddr = {NW'(wr_node), wr_lvl};
	assign dep_raddr = cmd.dep_rd_b ? NW'(b_q) : NW'(a_q);

	blca_ram #(.WIDTH(8), .DEPTH(TDEPTH)) u_tbl (
		.clk   (clk),
		.we    (cmd.tbl_we),
		.waddr (tbl_waddr),
		.wdata (wr_data),
		.re    (cmd.tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rd)
	);

	blca_ram #(.WIDTH(9), .DEPTH(NODES)) u_dep (
		.clk   (clk),
		.we    (cmd.dep_we),
		.waddr (NW'(j_q[7:0])),
		.wdata (d_q),
		.re    (cmd.dep_re),
		.raddr (dep_raddr),
		.rdata (dep_rd)
	);

	always_comb begin
		st.kind       = kind_q;
		st.a_valid    = node_ok(a_q, node_count_q);
		st.b_valid    = node_ok(b_q, node_count_q);
		st.rd_valid   = node_ok(tbl_rd, node_count_q);
		st.ready      = ready_q;
		st.j_in_range = (j_q <= {1'b0, node_count_q}) && (32'(j_q) < NODES);
		st.lvl_lt     = (32'(lvl_q) < LEVELS);
		st.lvl_zero   = (lvl_q == '0);
		st.k_bit      = k_q[lvl_idx];
		st.walk_on    = (tbl_rd != a_q) && (d_q < {1'b0, node_count_q});
		st.a_eq_b     = (a_q == b_q);
		st.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 8'd1;
			ready_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			j_q          <= '0;
			lvl_q        <= '0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
				ready_q      <= 1'b0;
			end else if (cmd.ready_clr) begin
				ready_q <= 1'b0;
			end else if (cmd.ready_set) begin
				ready_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.j_init) begin
				j_q <= 9'd1;
			end else if (cmd.j_inc) begin
				j_q <= j_q + 9'd1;
			end
			if (cmd.load_in || cmd.depth_cmp || cmd.lvl_top) begin
				lvl_q <= (LW+1)'(LEVELS - 1);
			end else if (cmd.lvl_one) begin
				lvl_q <= (LW+1)'(1);
			end else if (cmd.lvl_inc) begin
				lvl_q <= lvl_q + (LW+1)'(1);
			end else if (cmd.lvl_dec) begin
				lvl_q <= lvl_q - (LW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= in_kind;
			a_q    <= in_node_a;
			b_q    <= in_node_b;
			k_q    <= LEVELS'(in_steps);
		end
		if (cmd.depth_cmp) begin
			if (dep_rd > d_q) begin
				a_q <= b_q;
				b_q <= a_q;
				k_q <= LEVELS'(dep_rd - d_q);
			end else begin
				k_q <= LEVELS'(d_q - dep_rd);
			end
		end
		if (cmd.a_ld_j) begin
			a_q <= j_q[7:0];
			d_q <= 9'd1;
		end
		if (cmd.a_ld_rd) begin
			a_q <= tbl_rd;
		end
		if (cmd.d_inc) begin
			d_q <= d_q + 9'd1;
		end
		if (cmd.d_ld_dep) begin
			d_q <= dep_rd;
		end
		if (cmd.t_ld_rd) begin
			t_q <= tbl_rd;
		end
		if (cmd.lift && (t_q != tbl_rd)) begin
			a_q <= t_q;
			b_q <= tbl_rd;
		end
		if (cmd.res_set) begin
			case (cmd.res_sel)
				RES_A: begin
					res_node_q  <= a_q;
					res_found_q <= 1'b1;
				end
				RES_PAR: begin
					res_node_q  <= (t_q == tbl_rd) ? t_q : 8'd0;
					res_found_q <= (t_q == tbl_rd);
				end
				default: begin
					res_node_q  <= 8'd0;
					res_found_q <= 1'b0;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_node_q  <= res_node_q;
			out_found_q <= res_found_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_node  = out_node_q;
	assign out_found = out_found_q;

`ifndef SYNTHESIS
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_found_q || out_node_q == 8'd0))
		else $error("Result without an answer carries a nonzero node.");
	a_cfg_clears_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !ready_q)
		else $error("Table still marked ready after a node count write.");
	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("Result loaded over one not yet taken.");
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(lvl_q) <= LEVELS)
		else $error("Level counter out of range.");
`endif

endmodule

// ----- sim/tb_binary_lifting_ancestor_lca_unit.sv -----
// Self-checking testbench for the binary lifting ancestor and LCA unit.
`timescale 1ns / 100ps

module tb_binary_lifting_ancestor_lca_unit;
	import blca_pkg::*;

	localparam int NODES = 256;
	localparam int LEVELS = 8;
	localparam int CYCLE_LIMIT = 10000000;
	localparam int SETTLE = 100;

	typedef struct {
		logic [7:0] node;
		logic       found;
	} answer_t;

	typedef struct {
		logic       is_cfg;
		kind_t      kind;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] k;
		logic       typed;
		logic [7:0] node;
		logic       found;
	} dir_row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [7:0]  cfg_wdata = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = 0;
	logic [1:0]  s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [7:0]  m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	logic [7:0] anc [NODES][LEVELS];
	logic [8:0] depth_of [NODES];
	logic       built = 0;
	logic [7:0] node_count = 1;

	answer_t answers_due[$];
	dir_row_t dir_rows[$];
	int errors = 0;
	int sent = 0;
	int answered = 0;
	int cycles = 0;
	int hold_cnt = 0;
	bit held_once = 0;

	binary_lifting_ancestor_lca_unit #(.NODES(NODES), .LEVELS(LEVELS)) uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic bit valid_node(input logic [7:0] x);
		return x >= 1 && x <= node_count;
	endfunction

	function automatic logic [7:0] climb(input logic [7:0] x, input logic [7:0] k);
		for (int i = LEVELS - 1; i >= 0; i--)
			if (k[i])
				x = anc[x][i];
		return x;
	endfunction

	function automatic void build_table();
		logic [7:0] cur;
		int d;
		for (int j = 1; j <= node_count; j++)
			if (!valid_node(anc[j][0]))
				anc[j][0] = 8'(j);
		for (int i = 1; i < LEVELS; i++)
			for (int j = 1; j <= node_count; j++)
				anc[j][i] = anc[anc[j][i-1]][i-1];
		for (int j = 1; j <= node_count; j++) begin
			cur = 8'(j);
			d = 1;
			while (anc[cur][0] != cur && d < node_count) begin
				cur = anc[cur][0];
				d++;
			end
			depth_of[j] = 9'(d);
		end
		built = 1;
	endfunction

	// Updates the tree state for one command and returns 1 when it yields an answer.
	function automatic bit predict_answer(input kind_t kind, input logic [7:0] a,
			input logic [7:0] b, input logic [7:0] k, output answer_t ans);
		logic [8:0] da, db;
		logic [7:0] pa, pb;
		ans.node = 0;
		ans.found = 0;
		case (kind)
			KIND_LOAD: begin
				if (valid_node(a)) begin
					anc[a][0] = b;
					built = 0;
				end
				return 0;
			end
			KIND_BUILD: begin
				build_table();
				return 0;
			end
			default: ;
		endcase
		if (!built || !valid_node(a))
			return 1;
		if (kind == KIND_KTH) begin
			ans.node = climb(a, k);
			ans.found = 1;
			return 1;
		end
		if (!valid_node(b))
			return 1;
		da = depth_of[a];
		db = depth_of[b];
		if (da > db)
			a = climb(a, 8'(da - db));
		else
			b = climb(b, 8'(db - da));
		if (a == b) begin
			ans.node = a;
			ans.found = 1;
			return 1;
		end
		for (int i = LEVELS - 1; i >= 0; i--) begin
			pa = anc[a][i];
			pb = anc[b][i];
			if (pa != pb) begin
				a = pa;
				b = pb;
			end
		end
		if (anc[a][0] == anc[b][0]) begin
			ans.node = anc[a][0];
			ans.found = 1;
		end
		return 1;
	endfunction

	task automatic send(input kind_t kind, input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] k, input bit typed = 0, input logic [7:0] tnode = 0,
			input logic tfound = 0);
		answer_t ans;
		bit quiet;
		quiet = sent >= 900 && sent < 1100;
		while (!quiet && $urandom_range(99) < 18) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {k, b, a};
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (predict_answer(kind, a, b, k, ans)) begin
			if (typed) begin
				ans.node = tnode;
				ans.found = tfound;
			end
			answers_due.insert(answers_due.size(), ans);
		end
		sent++;
		@(negedge clk);
	endtask

	task automatic write_count(input logic [7:0] v);
		s_axis_tvalid <= 0;
		while (answers_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		node_count = v;
		built = 0;
	endtask

	task automatic row(input logic is_cfg, input kind_t kind, input logic [7:0] a,
			input logic [7:0] b, input logic [7:0] k, input logic typed = 0,
			input logic [7:0] node = 0, input logic found = 0);
		dir_row_t r;
		r = '{is_cfg, kind, a, b, k, typed, node, found};
		dir_rows.insert(dir_rows.size(), r);
	endtask

	function automatic logic [7:0] pick_node(input int n);
		if ($urandom_range(99) < 90)
			return 8'($urandom_range(n, 1));
		return 8'($urandom_range(255, 0));
	endfunction

	// shape 0: random tree, 1: chain, 2: arbitrary parents with cycles and forests.
	task automatic run_phase(input int n, input int shape);
		logic [7:0] p;
		int nq;
		write_count(8'(n));
		if ($urandom_range(99) < 10)
			send(KIND_KTH, pick_node(n), 8'd0, 8'($urandom));
		for (int j = 1; j <= n; j++) begin
			if (shape == 1)
				p = (j == 1) ? 8'd1 : 8'(j - 1);
			else if (shape == 2 || $urandom_range(99) < 8)
				p = 8'($urandom_range(255, 0));
			else
				p = (j == 1 || $urandom_range(99) < 5) ? 8'(j) :
					8'($urandom_range(j - 1, 1));
			send(KIND_LOAD, 8'(j), p, 8'($urandom));
			if (n < 255 && $urandom_range(99) < 5)
				send(KIND_LOAD,
					$urandom_range(99) < 30 ? 8'd0 : 8'($urandom_range(255, n + 1)),
					8'($urandom), 8'($urandom));
		end
		send(KIND_BUILD, 8'($urandom), 8'($urandom), 8'($urandom));
		nq = $urandom_range(45, 15);
		for (int q = 0; q < nq; q++) begin
			if ($urandom_range(99) < 4)
				send(KIND_LOAD, 8'($urandom_range(n, 1)), 8'($urandom_range(n, 1)),
					8'($urandom));
			else if (!built && $urandom_range(99) < 50)
				send(KIND_BUILD, 8'($urandom), 8'($urandom), 8'($urandom));
			send($urandom_range(1) ? KIND_KTH : KIND_LCA, pick_node(n), pick_node(n),
				8'($urandom));
		end
		send(KIND_KTH, pick_node(n), 8'($urandom), 8'($urandom));
	endtask

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			answered++;
			if (answers_due.size() == 0) begin
				report($sformatf("unexpected answer node %0d found %0d",
					m_axis_tdata, m_axis_tuser));
			end else begin
				e = answers_due.pop_front();
				if (m_axis_tdata !== e.node)
					report($sformatf("answer node %0d, expected %0d", m_axis_tdata, e.node));
				if (m_axis_tuser[0] !== e.found)
					report($sformatf("found %0d, expected %0d", m_axis_tuser, e.found));
			end
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 0;
			end else if (!held_once && answered >= 200) begin
				held_once = 1;
				hold_cnt = 400;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= (answered >= 500 && answered < 700) ||
					$urandom_range(99) >= 18;
			end
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		row(0, KIND_KTH, 1, 0, 0, 1, 0, 0);
		row(0, KIND_LCA, 1, 1, 0, 1, 0, 0);
		row(0, KIND_LOAD, 1, 0, 0);
		row(0, KIND_LOAD, 0, 5, 0);
		row(0, KIND_LOAD, 255, 255, 0);
		row(0, KIND_BUILD, 0, 0, 0);
		row(0, KIND_KTH, 1, 0, 255, 1, 1, 1);
		row(0, KIND_LCA, 1, 1, 0, 1, 1, 1);
		row(0, KIND_KTH, 0, 0, 0, 1, 0, 0);
		row(0, KIND_KTH, 2, 0, 0, 1, 0, 0);
		row(1, KIND_LOAD, 8, 0, 0);
		row(0, KIND_KTH, 1, 0, 0, 1, 0, 0);
		row(0, KIND_LOAD, 1, 1, 0);
		row(0, KIND_LOAD, 2, 1, 0);
		row(0, KIND_LOAD, 3, 1, 0);
		row(0, KIND_LOAD, 4, 2, 0);
		row(0, KIND_LOAD, 5, 4, 0);
		row(0, KIND_LOAD, 6, 0, 0);
		row(0, KIND_LOAD, 7, 8, 0);
		row(0, KIND_LOAD, 8, 7, 0);
		row(0, KIND_BUILD, 0, 0, 0);
		row(0, KIND_LCA, 5, 3, 0, 1, 1, 1);
		row(0, KIND_LCA, 5, 6, 0, 1, 0, 0);
		row(0, KIND_KTH, 5, 0, 3, 1, 1, 1);
		row(0, KIND_LCA, 7, 8, 0);
		row(0, KIND_LCA, 4, 4, 0, 1, 4, 1);
		row(0, KIND_LCA, 0, 3, 0, 1, 0, 0);
		row(0, KIND_LCA, 3, 9, 0, 1, 0, 0);
		row(0, KIND_KTH, 8, 0, 255);
		row(0, KIND_LOAD, 2, 3, 0);
		row(0, KIND_KTH, 5, 0, 1, 1, 0, 0);
		row(0, KIND_BUILD, 0, 0, 0);
		row(0, KIND_KTH, 5, 0, 2);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				write_count(dir_rows[i].a);
			else
				send(dir_rows[i].kind, dir_rows[i].a, dir_rows[i].b, dir_rows[i].k,
					dir_rows[i].typed, dir_rows[i].node, dir_rows[i].found);
		end

		run_phase(255, 1);
		run_phase(255, 0);
		run_phase(1, 0);
		while (sent < 1730) begin
			if ($urandom_range(99) < 5)
				run_phase($urandom_range(200, 40), 0);
			else
				run_phase($urandom_range(16, 2), $urandom_range(99) < 20 ? 2 : 0);
		end

		s_axis_tvalid <= 0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/blca_pkg.sv
sv/blca_ram.sv
sv/blca_ctrl.sv
sv/blca_dp.sv
sv/binary_lifting_ancestor_lca_unit.sv
sim/tb_binary_lifting_ancestor_lca_unit.sv
